### src/osvf_pkg.sv
// shared types, constants and microcode table for the oversampled state-variable filter
package osvf_pkg;

   // number format and iteration count
   localparam int FRAC_BITS = 16;
   localparam int PASSES    = 3;
   localparam int COEF_BITS = 16;

   // datapath widths
   localparam int SAMPLE_W = 32;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int NOTCH_W  = 35;
   localparam int HIGH_W   = 36;
   localparam int FH_W     = 35;
   localparam int MAG_W    = SAMPLE_W + 1;
   localparam int PASS_W   = (PASSES > 1) ? $clog2(PASSES) : 1;

   // configuration registers
   localparam int CUTOFF_W = 15;
   localparam int DAMP_W   = 19;
   localparam int DIST_W   = 18;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTORTION = 2'd2;

   localparam logic [CUTOFF_W-1:0]      CUTOFF_MAX = 15'd16384;
   localparam logic signed [DAMP_W-1:0] DAMP_MAX   = 19'sd131072;

   // magnitude above which a state is cleared
   localparam int CLEAR_WHOLE = 1000;
   localparam logic [63:0] CLEAR_LIMIT = 64'(CLEAR_WHOLE) << FRAC_BITS;

   // microcode program
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_FIRST  = 4'd0;
   localparam logic [PC_W-1:0] PC_FINISH = 4'd8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_D_BAND,
      MUL_F_BAND,
      MUL_BAND_SQ,
      MUL_SQ_BAND,
      MUL_F_HIGH,
      MUL_DIST_CUBE
   } mul_op_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_NOTCH,
      WB_LOW,
      WB_SQ,
      WB_HIGH,
      WB_CUBE,
      WB_FH,
      WB_BAND
   } wb_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_FINISH
   } seq_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      wb_op_type  wb_op;
      seq_op_type seq_op;
   } ctrl_word_type;

   // a step starts at most one product and may write back the product of the step before
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         4'd0:    w = '{MUL_D_BAND,    WB_NONE,  SEQ_NEXT};
         4'd1:    w = '{MUL_F_BAND,    WB_NOTCH, SEQ_NEXT};
         4'd2:    w = '{MUL_BAND_SQ,   WB_LOW,   SEQ_NEXT};
         4'd3:    w = '{MUL_NONE,      WB_SQ,    SEQ_NEXT};
         4'd4:    w = '{MUL_SQ_BAND,   WB_HIGH,  SEQ_NEXT};
         4'd5:    w = '{MUL_F_HIGH,    WB_CUBE,  SEQ_NEXT};
         4'd6:    w = '{MUL_DIST_CUBE, WB_FH,    SEQ_NEXT};
         4'd7:    w = '{MUL_NONE,      WB_BAND,  SEQ_LOOP};
         default: w = '{MUL_NONE,      WB_NONE,  SEQ_FINISH};
      endcase
      return w;
   endfunction

   // clamp a wide signed value to the 32-bit range
   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if ((&v[PROD_W-1:SAMPLE_W-1]) || !(|v[PROD_W-1:SAMPLE_W-1])) begin
         r = v[SAMPLE_W-1:0];
      end else if (v[PROD_W-1]) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### src/oversampled_state_variable_filter_top.sv
// oversampled state-variable lowpass filter run by a microcoded sequencer
//
//   port group   dir   transfer when          payload
//   req_*        in    req_valid & ready      req_sample_in
//   rsp_*        out   rsp_valid & ready      rsp_sample_out, rsp_state_cleared
//   csr_*        in    csr_wr_en              csr_wr_index, csr_wr_data
//
// a transferred sample runs the eight-step program once per pass for PASSES passes,
// the program sharing one 36x32 multiplier, and then one finish step that writes the
// result; the next transfer is taken in the idle state after the finish step
// the final step waits while an earlier result is still untaken
// a new sample is taken as soon as the program ends, even with a result pending
// synchronous reset clears both filter states and loads the default coefficients
module oversampled_state_variable_filter_top
   import osvf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_state_cleared,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_wr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data
);

   state_type                   state_ff, state_in;
   logic [PC_W-1:0]             pc_ff, pc_in;
   logic [PASS_W-1:0]           pass_ff, pass_in;
   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [NOTCH_W-1:0]   notch_ff, notch_in;
   logic signed [HIGH_W-1:0]    high_ff, high_in;
   logic signed [SAMPLE_W-1:0]  sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0]  cube_ff, cube_in;
   logic signed [FH_W-1:0]      fh_ff, fh_in;
   logic signed [SAMPLE_W-1:0]  low_ff, low_in;
   logic signed [SAMPLE_W-1:0]  band_ff, band_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                        rsp_cleared_ff, rsp_cleared_in;

   logic [CUTOFF_W-1:0]         cutoff_ff;
   logic signed [DAMP_W-1:0]    damp_ff;
   logic [DIST_W-1:0]           dist_ff;

   logic [CUTOFF_W-1:0]         f_eff;
   logic signed [DAMP_W-1:0]    d_eff;
   ctrl_word_type               ctrl;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    prod_coef;
   logic signed [PROD_W-1:0]    prod_frac;
   logic [MAG_W-1:0]            low_mag;
   logic [MAG_W-1:0]            band_mag;
   logic                        low_over;
   logic                        band_over;
   logic                        out_free;

   assign f_eff = (cutoff_ff > CUTOFF_MAX) ? CUTOFF_MAX : cutoff_ff;
   assign d_eff = (damp_ff > DAMP_MAX) ? DAMP_MAX : damp_ff;

   assign ctrl      = ucode_rom(pc_ff);
   assign prod_coef = prod_ff >>> COEF_BITS;
   assign prod_frac = prod_ff >>> FRAC_BITS;

   assign low_mag   = low_ff[SAMPLE_W-1] ? -MAG_W'(low_ff) : MAG_W'(low_ff);
   assign band_mag  = band_ff[SAMPLE_W-1] ? -MAG_W'(band_ff) : MAG_W'(band_ff);
   assign low_over  = 64'(low_mag) > CLEAR_LIMIT;
   assign band_over = 64'(band_mag) > CLEAR_LIMIT;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_state_cleared = rsp_cleared_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_op)
         MUL_D_BAND: begin
            mul_a = MUL_A_W'(band_ff);
            mul_b = MUL_B_W'(d_eff);
         end
         MUL_F_BAND: begin
            mul_a = MUL_A_W'(band_ff);
            mul_b = signed'(MUL_B_W'(f_eff));
         end
         MUL_BAND_SQ: begin
            mul_a = MUL_A_W'(band_ff);
            mul_b = MUL_B_W'(band_ff);
         end
         MUL_SQ_BAND: begin
            mul_a = MUL_A_W'(sq_ff);
            mul_b = MUL_B_W'(band_ff);
         end
         MUL_F_HIGH: begin
            mul_a = high_ff;
            mul_b = signed'(MUL_B_W'(f_eff));
         end
         MUL_DIST_CUBE: begin
            mul_a = MUL_A_W'(cube_ff);
            mul_b = signed'(MUL_B_W'(dist_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sequencer and write-back
   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      pass_in        = pass_ff;
      x_in           = x_ff;
      notch_in       = notch_ff;
      high_in        = high_ff;
      sq_in          = sq_ff;
      cube_in        = cube_ff;
      fh_in          = fh_ff;
      low_in         = low_ff;
      band_in        = band_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_cleared_in = rsp_cleared_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               pc_in    = PC_FIRST;
               pass_in  = '0;
               x_in     = req_sample_in;
            end
         end
         ST_RUN: begin
            case (ctrl.wb_op)
               WB_NOTCH: notch_in = NOTCH_W'(x_ff) - NOTCH_W'(prod_coef);
               WB_LOW:   low_in   = sat32(PROD_W'(low_ff) + prod_coef);
               WB_SQ:    sq_in    = sat32(prod_frac);
               WB_HIGH:  high_in  = HIGH_W'(notch_ff) - HIGH_W'(low_ff);
               WB_CUBE:  cube_in  = sat32(prod_frac);
               WB_FH:    fh_in    = FH_W'(prod_coef);
               WB_BAND:  band_in  = sat32(PROD_W'(fh_ff) + PROD_W'(band_ff) - prod_coef);
               default: ;
            endcase

            case (ctrl.seq_op)
               SEQ_NEXT: pc_in = pc_ff + 1'b1;
               SEQ_LOOP: begin
                  if (pass_ff == PASS_W'(PASSES - 1)) begin
                     pc_in = PC_FINISH;
                  end else begin
                     pc_in   = PC_FIRST;
                     pass_in = pass_ff + 1'b1;
                  end
               end
               SEQ_FINISH: begin
                  if (out_free) begin
                     rsp_valid_in   = 1'b1;
                     rsp_sample_in  = low_ff >>> 1;
                     rsp_cleared_in = low_over || band_over;
                     if (low_over) begin
                        low_in = '0;
                     end
                     if (band_over) begin
                        band_in = '0;
                     end
                     state_in = ST_IDLE;
                  end
               end
               default: pc_in = PC_FINISH;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_FIRST;
         pass_ff      <= '0;
         low_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         pass_ff      <= pass_in;
         low_ff       <= low_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      prod_ff        <= prod_in;
      notch_ff       <= notch_in;
      high_ff        <= high_in;
      sq_ff          <= sq_in;
      cube_ff        <= cube_in;
      fh_ff          <= fh_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_cleared_ff <= rsp_cleared_in;
   end

   // coefficient registers, writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= '0;
         damp_ff   <= DAMP_MAX;
         dist_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_wr_index)
            CSR_CUTOFF:     cutoff_ff <= csr_wr_data[CUTOFF_W-1:0];
            CSR_DAMPING:    damp_ff   <= signed'(csr_wr_data[DAMP_W-1:0]);
            CSR_DISTORTION: dist_ff   <= csr_wr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (pc_ff == PC_FIRST && pass_ff == '0 && state_ff == ST_RUN))
      else $error("program did not start at first step and pass");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> ($past(pc_ff) == PC_FINISH && $past(state_ff) == ST_RUN))
      else $error("result appeared outside the finish step");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pass_ff <= PASS_W'(PASSES - 1) && pc_ff <= PC_FINISH))
      else $error("sequencer ran past its program");

   a_clear_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid) && rsp_state_cleared) |-> (low_ff == '0 || band_ff == '0))
      else $error("clear flag set but no state was cleared");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && ctrl.seq_op != SEQ_FINISH) |=> (state_ff == ST_RUN))
      else $error("program left before its finish step");
`endif

endmodule
